>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed in %m");
// When ante holds, cons must hold at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");
// When ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/drm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// Types, codes and helpers of the detector run marker.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int SUM_W   = 48;
  localparam int TIME_W  = 40;
  localparam int TOTAL_W = 32;
  localparam int QUOT_W  = SUM_W + 1;

  localparam logic signed [11:0] PEAK_FLOOR = -12'sd1200;

  localparam logic [1:0] KIND_ONSET   = 2'd0;
  localparam logic [1:0] KIND_TONAL   = 2'd1;
  localparam logic [1:0] KIND_SOUND   = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [2:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [2:0] REG_MIN_RUN    = 3'd1;
  localparam logic [2:0] REG_WANT_ONSET = 3'd2;
  localparam logic [2:0] REG_WANT_TONAL = 3'd3;
  localparam logic [2:0] REG_WANT_SOUND = 3'd4;
  localparam logic [2:0] REG_MAX_MARKS  = 3'd5;

  typedef struct packed {
    logic                op;
    logic [TIME_W-1:0]   frame_end;
    logic                onset_flag;
    logic                tonal_flag;
    logic                voice_flag;
    logic signed [11:0]  level_db;
    logic [15:0]         spectral_flux;
    logic [14:0]         pitch_hz;
    logic [15:0]         periodicity;
  } item_t;

  typedef struct packed {
    logic [1:0]          mark_kind;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   run_length;
    logic signed [11:0]  peak_db;
    logic [14:0]         mean_hz;
    logic [15:0]         mean_periodicity;
    logic [15:0]         flux_out;
    logic                truncated;
    logic [TOTAL_W-1:0]  onset_total;
    logic [TOTAL_W-1:0]  tonal_run_total;
    logic [TOTAL_W-1:0]  sound_run_total;
    logic                last;
  } mark_t;

  typedef struct packed {
    logic [15:0] window_len;
    logic [31:0] min_run_samples;
    logic        want_onsets;
    logic        want_tonal;
    logic        want_sound;
    logic [15:0] max_marks;
  } cfg_t;

  // One pending mark; tonal marks still need their means worked out.
  typedef struct packed {
    mark_t              mark;
    logic [SUM_W-1:0]   pitch_sum;
    logic [SUM_W-1:0]   period_sum;
    logic [SUM_W-1:0]   frames;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_EVAL, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} back_state_t;

  // Saturating add of two sums.
  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

endpackage

>>> design/detector_run_marker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_run_marker
// Turns detector frames into onset, tonal run, sound run and summary marks.
// ----------------------------------------------------------------------------
// Channel   Ports                                   Transaction when
// item      push, full, item                        push && !full
// mark      pop, empty, mark                        pop && !empty
// config    psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//           prdata, pready
//
// The front end takes an item, evaluates it and then queues the marks that it
// causes one at a time while the job queue has room; full stays high until
// its marks are queued.
// A tonal run mark waits in the back end for the two bit-serial mean
// dividers (49 quotient bits); other marks go straight from idle to output.
// A two-entry job queue and a two-entry result queue let front and back
// stall independently. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module detector_run_marker import drm_pkg::*; #(
  parameter int TIME_BITS  = 40,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  item_t       item,
  input  logic        pop,
  output logic        empty,
  output mark_t       mark,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       reg_wr;
  logic       jq_push;
  job_t       jq_wdata;
  logic       jq_full;
  logic       jq_pop;
  job_t       jq_rdata;
  logic       jq_empty;
  logic       oq_push;
  mark_t      oq_wdata;
  logic       oq_full;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len      <= 16'd400;
      cfg.min_run_samples <= 32'd0;
      cfg.want_onsets     <= 1'b1;
      cfg.want_tonal      <= 1'b1;
      cfg.want_sound      <= 1'b1;
      cfg.max_marks       <= 16'd4096;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_WINDOW_LEN: cfg.window_len      <= pwdata[15:0];
        REG_MIN_RUN:    cfg.min_run_samples <= pwdata;
        REG_WANT_ONSET: cfg.want_onsets     <= pwdata[0];
        REG_WANT_TONAL: cfg.want_tonal      <= pwdata[0];
        REG_WANT_SOUND: cfg.want_sound      <= pwdata[0];
        REG_MAX_MARKS:  cfg.max_marks       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LEN: prdata = {16'd0, cfg.window_len};
      REG_MIN_RUN:    prdata = cfg.min_run_samples;
      REG_WANT_ONSET: prdata = {31'd0, cfg.want_onsets};
      REG_WANT_TONAL: prdata = {31'd0, cfg.want_tonal};
      REG_WANT_SOUND: prdata = {31'd0, cfg.want_sound};
      REG_MAX_MARKS:  prdata = {16'd0, cfg.max_marks};
      default:        prdata = 32'd0;
    endcase
  end

  drm_front #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .item    (item),
    .jq_push (jq_push),
    .jq_data (jq_wdata),
    .jq_full (jq_full)
  );

  drm_fifo #(
    .T     (job_t),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (jq_push),
    .wdata (jq_wdata),
    .full  (jq_full),
    .pop   (jq_pop),
    .rdata (jq_rdata),
    .empty (jq_empty)
  );

  drm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_empty (jq_empty),
    .jq_pop   (jq_pop),
    .jq_data  (jq_rdata),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata),
    .oq_full  (oq_full)
  );

  drm_fifo #(
    .T     (mark_t),
    .DEPTH (2)
  ) u_mark_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (mark),
    .empty (empty)
  );

endmodule

>>> design/drm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module drm_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> design/drm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_front
// Takes items, keeps the run state and cap, and queues the marks that
// each item causes, in order, as jobs for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module drm_front import drm_pkg::*; #(
  parameter int TIME_BITS  = 40,
  parameter int COUNT_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  jq_push,
  output job_t  jq_data,
  input  logic  jq_full
);

  localparam int TW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  front_state_t state, state_next;
  item_t        it;

  logic                  tonal_open;
  logic [TW-1:0]         tonal_start;
  logic [TW-1:0]         tonal_end;
  logic signed [11:0]    tonal_peak;
  logic [SUM_W-1:0]      pitch_sum;
  logic [SUM_W-1:0]      period_sum;
  logic [COUNT_BITS-1:0] tonal_frames;
  logic                  sound_open;
  logic [TW-1:0]         sound_start;
  logic [TW-1:0]         sound_end;
  logic signed [11:0]    sound_peak;
  logic [15:0]           marks_kept;
  logic                  dropped;
  logic [COUNT_BITS-1:0] onset_count;
  logic [COUNT_BITS-1:0] tonal_count;
  logic [COUNT_BITS-1:0] sound_count;

  job_t       slot [4];
  logic [3:0] slot_vld;
  logic [1:0] sel;
  logic [3:0] rest;

  // Classification of the held item.
  logic [TW-1:0]         fend;
  logic [TW-1:0]         win;
  logic [TW-1:0]         fstart;
  logic                  is_eos;
  logic                  on_need;
  logic                  tn_close;
  logic                  sd_close;
  logic [TW-1:0]         tn_len;
  logic [TW-1:0]         sd_len;
  logic                  tn_need;
  logic                  sd_need;
  logic                  ok_on;
  logic                  ok_tn;
  logic                  ok_sd;
  logic [15:0]           kept1;
  logic [15:0]           kept2;
  logic [15:0]           kept3;
  logic                  drop_a;
  logic                  drop_b;
  logic                  drop_c;
  logic signed [11:0]    tp_base;
  logic signed [11:0]    sp_base;
  logic [SUM_W-1:0]      ps_base;
  logic [SUM_W-1:0]      pr_base;
  logic [COUNT_BITS-1:0] tf_base;
  job_t                  s_on;
  job_t                  s_tn;
  job_t                  s_sd;
  job_t                  s_sum;

  always_comb begin
    fend   = it.frame_end[TW-1:0];
    win    = TW'(cfg.window_len);
    fstart = (fend >= win) ? fend - win : '0;
    is_eos = it.op;

    on_need  = !is_eos && it.onset_flag && cfg.want_onsets;
    tn_close = tonal_open && (is_eos || !it.tonal_flag);
    sd_close = sound_open && (is_eos || !it.voice_flag);
    tn_len   = tonal_end - tonal_start;
    sd_len   = sound_end - sound_start;
    tn_need  = tn_close && cfg.want_tonal && (tonal_end >= tonal_start) &&
               (TIME_W'(tn_len) >= TIME_W'(cfg.min_run_samples));
    sd_need  = sd_close && cfg.want_sound && (sound_end >= sound_start) &&
               (TIME_W'(sd_len) >= TIME_W'(cfg.min_run_samples));

    // The cap is checked in mark order: onset, tonal, sound.
    ok_on  = on_need && (marks_kept < cfg.max_marks);
    drop_a = dropped || (on_need && !ok_on);
    kept1  = marks_kept + 16'(ok_on);
    ok_tn  = tn_need && (kept1 < cfg.max_marks);
    drop_b = drop_a || (tn_need && !ok_tn);
    kept2  = kept1 + 16'(ok_tn);
    ok_sd  = sd_need && (kept2 < cfg.max_marks);
    drop_c = drop_b || (sd_need && !ok_sd);
    kept3  = kept2 + 16'(ok_sd);

    tp_base = tonal_open ? tonal_peak : PEAK_FLOOR;
    sp_base = sound_open ? sound_peak : PEAK_FLOOR;
    ps_base = tonal_open ? pitch_sum : '0;
    pr_base = tonal_open ? period_sum : '0;
    tf_base = tonal_open ? tonal_frames : '0;

    s_on                 = '0;
    s_on.mark.mark_kind  = KIND_ONSET;
    s_on.mark.start_time = TIME_W'(fstart);
    s_on.mark.peak_db    = it.level_db;
    s_on.mark.flux_out   = it.spectral_flux;
    s_on.mark.truncated  = drop_a;

    s_tn                 = '0;
    s_tn.mark.mark_kind  = KIND_TONAL;
    s_tn.mark.start_time = TIME_W'(tonal_start);
    s_tn.mark.run_length = TIME_W'(tn_len);
    s_tn.mark.peak_db    = tonal_peak;
    s_tn.mark.truncated  = drop_b;
    s_tn.pitch_sum       = pitch_sum;
    s_tn.period_sum      = period_sum;
    s_tn.frames          = SUM_W'(tonal_frames);

    s_sd                 = '0;
    s_sd.mark.mark_kind  = KIND_SOUND;
    s_sd.mark.start_time = TIME_W'(sound_start);
    s_sd.mark.run_length = TIME_W'(sd_len);
    s_sd.mark.peak_db    = sound_peak;
    s_sd.mark.truncated  = drop_c;

    s_sum                      = '0;
    s_sum.mark.mark_kind       = KIND_SUMMARY;
    s_sum.mark.truncated       = drop_c;
    s_sum.mark.onset_total     = TOTAL_W'(onset_count);
    s_sum.mark.tonal_run_total = TOTAL_W'(tonal_count);
    s_sum.mark.sound_run_total = TOTAL_W'(sound_count);
  end

  // Lowest-numbered pending slot goes out first.
  always_comb begin
    sel = '0;
    for (int i = 3; i >= 0; i--) begin
      if (slot_vld[i]) begin
        sel = 2'(i);
      end
    end
    rest = slot_vld & ~(4'b0001 << sel);
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (push) begin
          state_next = F_EVAL;
        end
      end
      F_EVAL: state_next = F_PUSH;
      F_PUSH: begin
        if (!(|slot_vld) || (!jq_full && !(|rest))) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full    = (state != F_IDLE);
    jq_push = (state == F_PUSH) && (|slot_vld) && !jq_full;
    jq_data = slot[sel];
    jq_data.mark.last = !(|rest);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      it <= item;
    end
    if (state == F_EVAL) begin
      slot[0] <= s_on;
      slot[1] <= s_tn;
      slot[2] <= s_sd;
      slot[3] <= s_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tonal_open   <= 1'b0;
      tonal_start  <= '0;
      tonal_end    <= '0;
      tonal_peak   <= PEAK_FLOOR;
      pitch_sum    <= '0;
      period_sum   <= '0;
      tonal_frames <= '0;
      sound_open   <= 1'b0;
      sound_start  <= '0;
      sound_end    <= '0;
      sound_peak   <= PEAK_FLOOR;
      marks_kept   <= '0;
      dropped      <= 1'b0;
      onset_count  <= '0;
      tonal_count  <= '0;
      sound_count  <= '0;
      slot_vld     <= '0;
    end else if (state == F_EVAL) begin
      marks_kept <= kept3;
      dropped    <= drop_c;
      slot_vld   <= {is_eos, ok_sd, ok_tn, ok_on};

      if (!is_eos && it.onset_flag && onset_count != CMAX) begin
        onset_count <= onset_count + COUNT_BITS'(1);
      end

      if (!is_eos && it.tonal_flag) begin
        if (!tonal_open) begin
          tonal_open  <= 1'b1;
          tonal_start <= fstart;
          if (tonal_count != CMAX) begin
            tonal_count <= tonal_count + COUNT_BITS'(1);
          end
        end
        tonal_end    <= fend;
        tonal_peak   <= (it.level_db > tp_base) ? it.level_db : tp_base;
        pitch_sum    <= sum_add(ps_base, SUM_W'(it.pitch_hz));
        period_sum   <= sum_add(pr_base, SUM_W'(it.periodicity));
        tonal_frames <= (tf_base == CMAX) ? tf_base : tf_base + COUNT_BITS'(1);
      end else if (tn_close) begin
        tonal_open <= 1'b0;
      end

      if (!is_eos && it.voice_flag) begin
        if (!sound_open) begin
          sound_open  <= 1'b1;
          sound_start <= fstart;
          if (sound_count != CMAX) begin
            sound_count <= sound_count + COUNT_BITS'(1);
          end
        end
        sound_end  <= fend;
        sound_peak <= (it.level_db > sp_base) ? it.level_db : sp_base;
      end else if (sd_close) begin
        sound_open <= 1'b0;
      end
    end else if (jq_push) begin
      slot_vld[sel] <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_eval_to_push, clk, rst, state == F_EVAL, state == F_PUSH)
  `ASSERT_IMPLY(a_idle_no_pending, clk, rst, state == F_IDLE, slot_vld == 4'b0000)
  `ASSERT_IMPLY(a_open_has_frames, clk, rst, tonal_open, tonal_frames != '0)

endmodule

>>> design/drm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drm_div import drm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QUOT_W-1:0] dividend,
  input  logic [SUM_W-1:0]  divisor,
  output logic              busy,
  output logic [QUOT_W-1:0] quotient
);

  localparam int CW = $clog2(QUOT_W);

  logic [CW-1:0]     cnt;
  logic [QUOT_W-1:0] dq;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dvs;
  logic [SUM_W:0]    shifted;
  logic [SUM_W:0]    diff;
  logic              ge;

  // dq shifts dividend bits out at the top and quotient bits in at the bottom.
  assign shifted  = {rem, dq[QUOT_W-1]};
  assign ge       = (shifted >= {1'b0, dvs});
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(QUOT_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[QUOT_W-2:0], ge};
      rem <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
    end
  end

endmodule

>>> design/drm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_back
// Takes queued jobs, works out the rounded tonal means and hands the
// finished marks to the result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module drm_back import drm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  jq_empty,
  output logic  jq_pop,
  input  job_t  jq_data,
  output logic  oq_push,
  output mark_t oq_data,
  input  logic  oq_full
);

  back_state_t       state, state_next;
  mark_t             cur;
  logic              need_div;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] hz_dividend;
  logic [QUOT_W-1:0] per_dividend;
  logic [QUOT_W-1:0] q_hz;
  logic [QUOT_W-1:0] q_per;
  logic              busy_hz;
  logic              busy_per;

  // Rounded mean: (sum + frames/2) / frames.
  assign need_div     = (jq_data.mark.mark_kind == KIND_TONAL) && (jq_data.frames != '0);
  assign hz_dividend  = {1'b0, jq_data.pitch_sum} + {2'b00, jq_data.frames[SUM_W-1:1]};
  assign per_dividend = {1'b0, jq_data.period_sum} + {2'b00, jq_data.frames[SUM_W-1:1]};
  assign div_done     = !busy_hz && !busy_per;

  drm_div u_div_hz (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hz_dividend),
    .divisor  (jq_data.frames),
    .busy     (busy_hz),
    .quotient (q_hz)
  );

  drm_div u_div_per (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (per_dividend),
    .divisor  (jq_data.frames),
    .busy     (busy_per),
    .quotient (q_per)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!jq_empty) begin
          state_next = need_div ? B_DIV : B_OUT;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!oq_full) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    jq_pop    = (state == B_IDLE) && !jq_empty;
    div_start = jq_pop && need_div;
    oq_push   = (state == B_OUT) && !oq_full;
    oq_data   = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      cur <= jq_data.mark;
    end else if (state == B_DIV && div_done) begin
      cur.mean_hz          <= q_hz[14:0];
      cur.mean_periodicity <= q_per[15:0];
    end
  end

  `ASSERT_ALWAYS(a_div_lockstep, clk, rst, busy_hz == busy_per)
  `ASSERT_IMPLY(a_div_tonal_only, clk, rst, state == B_DIV, cur.mark_kind == KIND_TONAL)
  `ASSERT_NEXT(a_div_to_out, clk, rst, state == B_DIV && div_done, state == B_OUT)

endmodule
